// ===== rtl/smcu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the swerve module command unit.
// Used by smcu_lane, smcu_merge and the top level; depends on nothing else.
package smcu_pkg;

	localparam int MODS             = 4;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ROWS        = 24;
	localparam int IDX_W            = 5;

	localparam int CMD_W  = 16;
	localparam int VEC_W  = 22;
	localparam int XY_W   = 32;
	localparam int Z_W    = 28;
	localparam int SPD_W  = 24;
	localparam int ANG_W  = 16;
	localparam int PROD_W = 61;
	localparam int OUT_W  = 32;
	localparam int REM_W  = 40;
	localparam int QUO_W  = 15;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [Z_W-1:0]   PI_Q24     = 28'sd52707179;
	localparam logic signed [Z_W-1:0]   PI_Q12_Z   = 28'sd12868;
	localparam logic [29:0]             GAIN_Q30   = 30'd652032874;
	localparam logic signed [17:0]      PI_Q12     = 18'sd12868;
	localparam logic signed [17:0]      HALF_PI    = 18'sd6434;
	localparam logic signed [17:0]      THR_HALF_PI = 18'sd19302;
	localparam logic signed [17:0]      TWO_PI     = 18'sd25736;
	localparam logic [SPD_W-1:0]        DESAT_FLOOR = 24'd10;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLES    = 3'd4;

	localparam int EN_DESAT = 0;
	localparam int EN_OPT   = 1;
	localparam int EN_RPM   = 2;

	typedef struct packed {
		logic                    done;
		logic [SPD_W-1:0]        speed;
		logic signed [ANG_W-1:0] angle;
	} lane_res_t;

	typedef enum logic [2:0] {
		TP_IDLE, TP_TB, TP_VEC, TP_LANE, TP_MERGE, TP_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		MG_IDLE, MG_DLOAD, MG_DIV, MG_OPT, MG_MUL, MG_SAT
	} merge_state_t;

	// atan(2^-i) in Q.24
	function automatic logic signed [Z_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
		logic signed [Z_W-1:0] r;
		begin
			case (i)
				5'd0:  r = 28'sd13176795;
				5'd1:  r = 28'sd7778716;
				5'd2:  r = 28'sd4110060;
				5'd3:  r = 28'sd2086331;
				5'd4:  r = 28'sd1047214;
				5'd5:  r = 28'sd524117;
				5'd6:  r = 28'sd262123;
				5'd7:  r = 28'sd131069;
				5'd8:  r = 28'sd65536;
				5'd9:  r = 28'sd32768;
				5'd10: r = 28'sd16384;
				5'd11: r = 28'sd8192;
				5'd12: r = 28'sd4096;
				5'd13: r = 28'sd2048;
				5'd14: r = 28'sd1024;
				5'd15: r = 28'sd512;
				5'd16: r = 28'sd256;
				5'd17: r = 28'sd128;
				5'd18: r = 28'sd64;
				5'd19: r = 28'sd32;
				5'd20: r = 28'sd16;
				5'd21: r = 28'sd8;
				5'd22: r = 28'sd4;
				5'd23: r = 28'sd2;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== rtl/smcu_lane.sv =====
`timescale 1ns / 1ps
// One module lane: vectoring CORDIC, one rotation per clock, then gain multiply.
// Keeps the held steering angle of its module. Depends on smcu_pkg.
module smcu_lane import smcu_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    cmd_zero,
	input  logic signed [VEC_W-1:0] vec_x,
	input  logic signed [VEC_W-1:0] vec_y,
	output lane_res_t               res
);

	logic signed [XY_W-1:0]  x_q, y_q, px, py, xs, ys;
	logic signed [Z_W-1:0]   z_q, zs, zsh;
	logic [IDX_W-1:0]        cnt_q;
	logic                    run_q, mul_q, fin_q, zero_q, done_q;
	logic [PROD_W-1:0]       prod_s1, rnd;
	logic [XY_W-2:0]         xpos;
	logic signed [ANG_W-1:0] zang, zang_s1, held_q, angle_q;
	logic [SPD_W-1:0]        mag, speed_q;

	always_comb begin
		px   = {{(XY_W-VEC_W){vec_x[VEC_W-1]}}, vec_x} <<< 8;
		py   = {{(XY_W-VEC_W){vec_y[VEC_W-1]}}, vec_y} <<< 8;
		xs   = x_q >>> cnt_q;
		ys   = y_q >>> cnt_q;
		xpos = x_q[XY_W-1] ? '0 : x_q[XY_W-2:0];
		zs   = z_q + Z_W'(2048);
		zsh  = zs >>> 12;
		if (zsh > PI_Q12_Z)
			zang = ANG_W'(PI_Q12_Z);
		else if (zsh < -PI_Q12_Z)
			zang = ANG_W'(-PI_Q12_Z);
		else
			zang = zsh[ANG_W-1:0];
		rnd = prod_s1 + (PROD_W'(1) << 37);
		mag = SPD_W'(rnd[PROD_W-1:38]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			mul_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			held_q <= '0;
		end else begin
			if (start) begin
				run_q  <= 1'b1;
				done_q <= 1'b0;
			end else if (run_q && cnt_q == IDX_W'(CORDIC_STEPS - 1)) begin
				run_q <= 1'b0;
			end
			mul_q <= run_q && cnt_q == IDX_W'(CORDIC_STEPS - 1);
			fin_q <= mul_q;
			if (fin_q) begin
				done_q <= 1'b1;
				if (!zero_q && mag != '0)
					held_q <= zang_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= cmd_zero;
			cnt_q  <= '0;
			// fold the left half plane onto the right before rotating
			if (px < 0) begin
				x_q <= -px;
				y_q <= -py;
				z_q <= (py >= 0) ? PI_Q24 : -PI_Q24;
			end else begin
				x_q <= px;
				y_q <= py;
				z_q <= '0;
			end
		end else if (run_q) begin
			cnt_q <= cnt_q + IDX_W'(1);
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q24(cnt_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q24(cnt_q);
			end
		end
		if (mul_q) begin
			prod_s1 <= PROD_W'(xpos) * PROD_W'(GAIN_Q30);
			zang_s1 <= zang;
		end
		if (fin_q) begin
			if (zero_q || mag == '0) begin
				speed_q <= '0;
				angle_q <= held_q;
			end else begin
				speed_q <= mag;
				angle_q <= zang_s1;
			end
		end
	end

	assign res.done  = done_q;
	assign res.speed = speed_q;
	assign res.angle = angle_q;

endmodule

// ===== rtl/smcu_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: desaturation with a shared bit-serial divider, angle optimization,
// rpm scaling and 32-bit saturation. Depends on smcu_pkg.
module smcu_merge import smcu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  lane_res_t               lane_res [MODS],
	input  logic signed [ANG_W-1:0] meas [MODS],
	input  logic [2:0]              enables,
	input  logic [14:0]             speed_limit,
	input  logic [15:0]             rpm_scale,
	output logic                    done,
	output logic signed [OUT_W-1:0] speed_out [MODS],
	output logic signed [ANG_W-1:0] angle_out [MODS]
);

	merge_state_t state_q, state_d;

	logic [SPD_W-1:0]        spd_q [MODS];
	logic signed [ANG_W-1:0] ang_q [MODS];
	logic [SPD_W-1:0]        hi_q, hi_a, hi_b, hi;
	logic                    des_q;
	logic [1:0]              mcnt_q;
	logic [3:0]              kcnt_q;
	logic [REM_W-1:0]        rem_q, dsh;
	logic [SPD_W+14:0]       pm;
	logic [QUO_W-1:0]        q_q, q_nx;
	logic                    ge;
	logic signed [SPD_W:0]   s_s1 [MODS];
	logic signed [ANG_W-1:0] ang_s1 [MODS];
	logic signed [41:0]      prod_s2 [MODS];
	logic                    ld_en, div_en, opt_en, mul_en;

	always_comb begin
		hi_a = (lane_res[0].speed > lane_res[1].speed) ? lane_res[0].speed : lane_res[1].speed;
		hi_b = (lane_res[2].speed > lane_res[3].speed) ? lane_res[2].speed : lane_res[3].speed;
		hi   = (hi_a > hi_b) ? hi_a : hi_b;
		pm   = spd_q[mcnt_q] * speed_limit;
		dsh  = REM_W'(hi_q) << kcnt_q;
		ge   = rem_q >= dsh;
		q_nx = {q_q[QUO_W-2:0], ge};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MG_IDLE:  if (start) state_d = MG_DLOAD;
			MG_DLOAD: state_d = des_q ? MG_DIV : MG_OPT;
			MG_DIV:   if (kcnt_q == 4'd0) state_d = (mcnt_q == 2'd3) ? MG_OPT : MG_DLOAD;
			MG_OPT:   state_d = MG_MUL;
			MG_MUL:   state_d = MG_SAT;
			MG_SAT:   state_d = MG_IDLE;
			default:  state_d = MG_IDLE;
		endcase
	end

	always_comb begin
		ld_en  = state_q == MG_DLOAD && des_q;
		div_en = state_q == MG_DIV;
		opt_en = state_q == MG_OPT;
		mul_en = state_q == MG_MUL;
		done   = state_q == MG_SAT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= MG_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == MG_IDLE && start) begin
			for (int i = 0; i < MODS; i++) begin
				spd_q[i] <= lane_res[i].speed;
				ang_q[i] <= lane_res[i].angle;
			end
			hi_q   <= hi;
			des_q  <= enables[EN_DESAT] && hi > DESAT_FLOOR && hi > SPD_W'(speed_limit);
			mcnt_q <= '0;
		end
		if (ld_en) begin
			rem_q  <= REM_W'(pm) + REM_W'(hi_q >> 1);
			kcnt_q <= 4'(QUO_W - 1);
			q_q    <= '0;
		end
		if (div_en) begin
			if (ge)
				rem_q <= rem_q - dsh;
			q_q    <= q_nx;
			kcnt_q <= kcnt_q - 4'd1;
			if (kcnt_q == 4'd0) begin
				spd_q[mcnt_q] <= SPD_W'(q_nx);
				mcnt_q        <= mcnt_q + 2'd1;
			end
		end
		if (opt_en) begin
			for (int i = 0; i < MODS; i++) begin
				logic signed [17:0] m, d, a;
				logic               flip;
				m = 18'(meas[i]);
				if (m > PI_Q12)
					m = m - TWO_PI;
				a = 18'(ang_q[i]);
				d = a - m;
				flip = 1'b0;
				if (enables[EN_OPT]) begin
					if (d >= HALF_PI && d <= THR_HALF_PI) begin
						a    = a - PI_Q12;
						flip = 1'b1;
					end else if (d <= -HALF_PI && d >= -THR_HALF_PI) begin
						a    = a + PI_Q12;
						flip = 1'b1;
					end
					if (a < 0)
						a = a + TWO_PI;
				end
				ang_s1[i] <= a[ANG_W-1:0];
				s_s1[i]   <= flip ? -$signed({1'b0, spd_q[i]}) : $signed({1'b0, spd_q[i]});
			end
		end
		if (mul_en) begin
			for (int i = 0; i < MODS; i++) begin
				// without rpm scaling, shift up so the common rounding returns s
				if (enables[EN_RPM])
					prod_s2[i] <= 42'(s_s1[i]) * $signed({26'd0, rpm_scale});
				else
					prod_s2[i] <= 42'(s_s1[i]) <<< 8;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MODS; i++) begin
			logic signed [41:0] r;
			r = (prod_s2[i] + 42'sd128) >>> 8;
			if (r > 42'sd2147483647)
				speed_out[i] = 32'sh7FFFFFFF;
			else if (r < -42'sd2147483648)
				speed_out[i] = 32'sh80000000;
			else
				speed_out[i] = r[OUT_W-1:0];
			angle_out[i] = ang_s1[i];
		end
	end

endmodule

// ===== rtl/swerve_module_command_unit_core.sv =====
`timescale 1ns / 1ps
// Swerve module command unit: inverse kinematics for four steered wheel modules.
// Top level: config registers, command decode, four CORDIC lanes and merge stage.
// Depends on smcu_pkg, smcu_lane and smcu_merge.
//
// One command beat is processed at a time. After acceptance the track and base
// products are registered, the four wheel vectors are formed from them and the
// four lanes run their CORDICs side by side. The merge stage then optimizes,
// scales and saturates; when desaturation triggers it first passes the four
// speeds one by one through one divider, with a load step and 15 quotient bits
// each. The next beat is accepted once the result has moved into the output
// register, so a stalled output adds its stall. Configuration writes are
// always accepted and must only be issued while the unit is idle.
module swerve_module_command_unit_core import smcu_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// vel_x, vel_y, yaw_rate, measured_angle_fl, _rl, _rr, _fr
	input  logic [111:0]          s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// speed_fl, angle_fl, speed_rl, angle_rl, speed_rr, angle_rr, speed_fr, angle_fr
	output logic [191:0]          m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	top_state_t state_q, state_d;

	logic [13:0] half_track_q, half_base_q;
	logic [14:0] speed_limit_q;
	logic [15:0] rpm_scale_q;
	logic [2:0]  enables_q;

	logic signed [CMD_W-1:0] vx_q, vy_q, w_q;
	logic signed [ANG_W-1:0] meas_q [MODS];
	logic signed [30:0]      tprod_s1, bprod_s1, tr, br;
	logic signed [VEC_W-1:0] t, b, vx, vy;
	logic signed [VEC_W-1:0] vec_x [MODS], vec_y [MODS];
	logic                    cmd_zero, all_done;
	logic                    in_load, lane_start, merge_start, out_load;
	lane_res_t               lane_res [MODS];
	logic                    merge_done;
	logic signed [OUT_W-1:0] speed_out [MODS];
	logic signed [ANG_W-1:0] angle_out [MODS];
	logic                    m_tvalid_q;
	logic [191:0]            m_tdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_track_q  <= 14'd256;
			half_base_q   <= 14'd256;
			speed_limit_q <= 15'd4096;
			rpm_scale_q   <= 16'd48892;
			enables_q     <= 3'd7;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HALF_TRACK: half_track_q  <= cfg_data[13:0];
				CFG_HALF_BASE:  half_base_q   <= cfg_data[13:0];
				CFG_MAX_SPEED:  speed_limit_q <= cfg_data[14:0];
				CFG_RPM_SCALE:  rpm_scale_q   <= cfg_data;
				CFG_ENABLES:    enables_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd_zero = vx_q == '0 && vy_q == '0 && w_q == '0;
		all_done = lane_res[0].done && lane_res[1].done && lane_res[2].done && lane_res[3].done;
		tr = tprod_s1 + 31'sd512;
		br = bprod_s1 + 31'sd512;
		t  = VEC_W'(tr >>> 10);
		b  = VEC_W'(br >>> 10);
		vx = VEC_W'(vx_q);
		vy = VEC_W'(vy_q);
		vec_x[0] = vx - t; vec_y[0] = vy - b;
		vec_x[1] = vx + t; vec_y[1] = vy - b;
		vec_x[2] = vx + t; vec_y[2] = vy + b;
		vec_x[3] = vx - t; vec_y[3] = vy + b;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TP_IDLE:  if (s_tvalid) state_d = TP_TB;
			TP_TB:    state_d = TP_VEC;
			TP_VEC:   state_d = TP_LANE;
			TP_LANE:  if (all_done) state_d = TP_MERGE;
			TP_MERGE: if (merge_done) state_d = TP_OUT;
			TP_OUT:   if (!m_tvalid_q || m_tready) state_d = TP_IDLE;
			default:  state_d = TP_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = state_q == TP_IDLE;
		in_load     = s_tready && s_tvalid;
		lane_start  = state_q == TP_VEC;
		merge_start = state_q == TP_LANE && all_done;
		out_load    = state_q == TP_OUT && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= TP_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			vx_q <= s_tdata[15:0];
			vy_q <= s_tdata[31:16];
			w_q  <= s_tdata[47:32];
			for (int i = 0; i < MODS; i++)
				meas_q[i] <= s_tdata[48 + 16*i +: 16];
		end
		if (state_q == TP_TB) begin
			tprod_s1 <= $signed({1'b0, half_track_q}) * w_q;
			bprod_s1 <= $signed({1'b0, half_base_q}) * w_q;
		end
		if (out_load) begin
			for (int i = 0; i < MODS; i++)
				m_tdata_q[48*i +: 48] <= {angle_out[i], speed_out[i]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	for (genvar g = 0; g < MODS; g++) begin : g_lane
		smcu_lane #(
			.CORDIC_STEPS(CORDIC_STEPS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (lane_start),
			.cmd_zero(cmd_zero),
			.vec_x   (vec_x[g]),
			.vec_y   (vec_y[g]),
			.res     (lane_res[g])
		);
	end

	smcu_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (merge_start),
		.lane_res   (lane_res),
		.meas       (meas_q),
		.enables    (enables_q),
		.speed_limit(speed_limit_q),
		.rpm_scale  (rpm_scale_q),
		.done       (merge_done),
		.speed_out  (speed_out),
		.angle_out  (angle_out)
	);

	// lanes share one start and one step count, so they finish together
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_res[0].done == lane_res[1].done && lane_res[0].done == lane_res[2].done &&
		lane_res[0].done == lane_res[3].done)
		else $error("lanes out of step");

	a_merge_done: assert property (@(posedge clk) disable iff (!arst_n)
		merge_done |-> state_q == TP_MERGE)
		else $error("merge finished outside its phase");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == TP_TB && !s_tready)
		else $error("command beat not taken into work");

endmodule
